@@ sv/shsm_pkg.sv @@
package shsm_pkg;

  // time width default
  localparam int TIME_BITS_DEF = 32;

  // phase and coil codes
  localparam logic [3:0] PHASE_OFF    = 4'd8;
  localparam logic [1:0] COIL_INVALID = 2'd3;
  localparam int         NUM_PHASES   = 8;
  localparam int         NUM_LINES    = 4;

  // sticky error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_TOO_FAST  = 3'd1;
  localparam logic [2:0] ERR_BOTH_HIGH = 3'd2;
  localparam logic [2:0] ERR_TURN_OFF  = 3'd3;
  localparam logic [2:0] ERR_JUMP      = 3'd4;

  // half-step phase table, coil 0 and coil 1 codes
  localparam logic [1:0] PHASE_COIL0 [NUM_PHASES] =
    '{2'd2, 2'd2, 2'd0, 2'd1, 2'd1, 2'd1, 2'd0, 2'd2};
  localparam logic [1:0] PHASE_COIL1 [NUM_PHASES] =
    '{2'd0, 2'd2, 2'd2, 2'd2, 2'd0, 2'd1, 2'd1, 2'd1};

  typedef struct packed {
    logic [3:0]  pin_levels;
    logic [31:0] now_us;
  } sample_t;

  typedef struct packed {
    logic [3:0] drive_pins;
    logic [3:0] phase;
    logic [2:0] error_code;
  } result_t;

  // monitor state carried along the line chain
  typedef struct packed {
    logic [3:0] accepted;
    logic [3:0] driven;
    logic [3:0] phase;
    logic [2:0] error;
    logic       stamped;
  } line_state_t;

  // look up the phase of a coil pair, PHASE_OFF when not in the table
  function automatic logic [3:0] phase_lookup(input logic [1:0] c0, input logic [1:0] c1);
    logic [3:0] found;
    found = PHASE_OFF;
    for (int p = NUM_PHASES - 1; p >= 0; p--) begin
      if (PHASE_COIL0[3'(p)] == c0 && PHASE_COIL1[3'(p)] == c1) begin
        found = 4'(p);
      end
    end
    return found;
  endfunction

endpackage

@@ sv/shsm_line.sv @@
module shsm_line
  import shsm_pkg::*;
(
  input  line_state_t st_in,
  input  logic [1:0]  idx,
  input  logic        level,
  input  logic        fast_first,
  input  logic        min_nonzero,
  output line_state_t st_out
);

  logic [3:0] acc_new;
  logic [1:0] coil0;
  logic [1:0] coil1;
  logic [3:0] found;
  logic [2:0] diff;
  logic       too_fast;

  // decode the coils from the accepted levels with this line applied
  always_comb begin
    acc_new      = st_in.accepted;
    acc_new[idx] = level;
    coil0        = {acc_new[0], acc_new[1]};
    coil1        = {acc_new[2], acc_new[3]};
    found        = phase_lookup(coil0, coil1);
    diff         = found[2:0] - st_in.phase[2:0];
    too_fast     = st_in.stamped ? min_nonzero : fast_first;
  end

  // handle one line change
  always_comb begin
    st_out = st_in;
    if (st_in.accepted[idx] != level) begin
      st_out.driven[idx] = level;
      if (too_fast) begin
        st_out.error = ERR_TOO_FAST;
      end else begin
        st_out.stamped  = 1'b1;
        st_out.accepted = acc_new;
        if (coil0 == COIL_INVALID || coil1 == COIL_INVALID) begin
          st_out.error = ERR_BOTH_HIGH;
        end else if (st_in.phase >= PHASE_OFF) begin
          st_out.phase = found;
        end else if (found == PHASE_OFF) begin
          st_out.error = ERR_TURN_OFF;
        end else if (diff != 3'd0 && diff != 3'd1 && diff != 3'd7) begin
          st_out.error = ERR_JUMP;
        end else begin
          st_out.phase = found;
        end
      end
    end
  end

endmodule

@@ sv/stepper_halfstep_sequence_monitor.sv @@
// channel  | direction | handshake       | payload
// ---------+-----------+-----------------+----------------------------------
// sample   | in        | valid / stall   | sample_t: pin_levels, now_us
// result   | out       | valid / stall   | result_t: drive_pins, phase, error_code
// cfg      | in        | valid / ready   | min_step_time, 32 bits
//
// one sample per cycle sustained while the result side is not stalled; an accepted sample passes through
// the sample register, then the four-line chain into the result register
// synchronous reset clears control state, phase to off, errors and timing to zero
// a stalled result holds; the sample register keeps filling the pipe until it too is full
// cfg_ready is always high
module stepper_halfstep_sequence_monitor
  import shsm_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  output logic        sample_stall,
  input  sample_t     sample,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_min_step_time
);

  // configuration and monitor state
  logic [31:0]          min_step_time;
  logic [3:0]           accepted_levels;
  logic [TIME_BITS-1:0] last_change_time;
  logic [3:0]           current_phase;
  logic [2:0]           latched_error;
  logic [3:0]           driven_levels;

  // sample register
  logic    held_full;
  sample_t held;

  logic                 out_free;
  logic                 advance;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] min_t;
  logic                 fast_first;
  logic                 min_nonzero;
  line_state_t          chain [NUM_LINES+1];

  assign cfg_ready    = 1'b1;
  assign out_free     = !result_valid || !result_stall;
  assign advance      = held_full && out_free;
  assign sample_stall = held_full && !out_free;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_step_time <= '0;
    end else if (cfg_valid && cfg_ready) begin
      min_step_time <= cfg_min_step_time;
    end
  end

  // sample register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_full <= 1'b0;
    end else if (sample_valid && !sample_stall) begin
      held_full <= 1'b1;
    end else if (advance) begin
      held_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      held <= sample;
    end
  end

  // elapsed-time check against the stored change time
  always_comb begin
    now_t       = TIME_BITS'(held.now_us);
    min_t       = TIME_BITS'(min_step_time);
    fast_first  = (now_t - last_change_time) < min_t;
    min_nonzero = (min_t != '0);
  end

  assign chain[0] = '{accepted: accepted_levels, driven: driven_levels,
                      phase: current_phase, error: latched_error, stamped: 1'b0};

  // four lines in order, line 0 first
  for (genvar i = 0; i < NUM_LINES; i++) begin : g_line
    shsm_line u_line (
      .st_in      (chain[i]),
      .idx        (2'(i)),
      .level      (held.pin_levels[i]),
      .fast_first (fast_first),
      .min_nonzero(min_nonzero),
      .st_out     (chain[i+1])
    );
  end

  // state update on each processed transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      accepted_levels  <= '0;
      last_change_time <= '0;
      current_phase    <= PHASE_OFF;
      latched_error    <= ERR_NONE;
      driven_levels    <= '0;
    end else if (advance) begin
      accepted_levels <= chain[NUM_LINES].accepted;
      current_phase   <= chain[NUM_LINES].phase;
      latched_error   <= chain[NUM_LINES].error;
      driven_levels   <= chain[NUM_LINES].driven;
      if (chain[NUM_LINES].stamped) begin
        last_change_time <= now_t;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= '{drive_pins: chain[NUM_LINES].driven, phase: chain[NUM_LINES].phase,
                  error_code: chain[NUM_LINES].error};
    end
  end

endmodule

@@ sv/shsm_checker.sv @@
module shsm_checker
  import shsm_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // an error has been reported on an earlier result
  logic err_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      err_seen <= 1'b0;
    end else if (result_valid && !result_stall && result.error_code != ERR_NONE) begin
      err_seen <= 1'b1;
    end
  end

  // phase is 0..7 or off
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.phase <= PHASE_OFF)
    else $error("phase out of range");

  // error code is a defined one
  a_error_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.error_code <= ERR_JUMP)
    else $error("error code out of range");

  // errors are sticky across transactions
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    result_valid && err_seen |-> result.error_code != ERR_NONE)
    else $error("sticky error cleared");

  // a stalled result stays
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

endmodule

bind stepper_halfstep_sequence_monitor shsm_checker u_shsm_checker (.*);

@@ verif/stepper_halfstep_sequence_monitor_test.sv @@
module stepper_halfstep_sequence_monitor_test;
  timeunit 1ns;
  timeprecision 1ps;
  import shsm_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 300;

  // pin levels that select each half-step phase
  localparam logic [3:0] STEP_PINS [NUM_PHASES] =
    '{4'h1, 4'h5, 4'h4, 4'h6, 4'h2, 4'hA, 4'h8, 4'h9};

  logic        clk;
  logic        rst;
  logic        sample_valid;
  logic        sample_stall;
  sample_t     sample;
  logic        result_valid;
  logic        result_stall;
  result_t     result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_min_step_time;

  stepper_halfstep_sequence_monitor dut (
    .clk               (clk),
    .rst               (rst),
    .sample_valid      (sample_valid),
    .sample_stall      (sample_stall),
    .sample            (sample),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .result            (result),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_min_step_time (cfg_min_step_time)
  );

  // own copy of the monitor state
  logic [3:0]  mon_accepted    = '0;
  logic [3:0]  mon_driven      = '0;
  logic [3:0]  mon_phase       = PHASE_OFF;
  logic [2:0]  mon_error       = ERR_NONE;
  logic [31:0] mon_last_change = '0;
  logic [31:0] mon_min_step    = '0;

  result_t status_queue [$];
  int      status_errors = 0;
  int      idle_cycles   = 0;
  int      hold_left     = 0;
  int      stall_left    = 0;
  bit      quiet_tx      = 1'b0;
  bit      quiet_rx      = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // walk the changed lines in order and return the status word that follows
  function automatic result_t apply_pin_sample(input sample_t s);
    logic [31:0] elapsed;
    logic [1:0]  coil_a;
    logic [1:0]  coil_b;
    logic [3:0]  found;
    logic [2:0]  phase_step;
    logic [1:0]  li;
    result_t     r;
    for (int i = 0; i < NUM_LINES; i++) begin
      li = 2'(i);
      if (mon_accepted[li] != s.pin_levels[li]) begin
        mon_driven[li] = s.pin_levels[li];
        elapsed = s.now_us - mon_last_change;
        if (elapsed < mon_min_step) begin
          mon_error = ERR_TOO_FAST;
        end else begin
          mon_last_change = s.now_us;
          mon_accepted[li] = s.pin_levels[li];
          coil_a = {mon_accepted[0], mon_accepted[1]};
          coil_b = {mon_accepted[2], mon_accepted[3]};
          if (coil_a == COIL_INVALID || coil_b == COIL_INVALID) begin
            mon_error = ERR_BOTH_HIGH;
          end else begin
            // half-step table lookup, coil 0 code then coil 1 code
            case ({coil_a, coil_b})
              4'b1000: found = 4'd0;
              4'b1010: found = 4'd1;
              4'b0010: found = 4'd2;
              4'b0110: found = 4'd3;
              4'b0100: found = 4'd4;
              4'b0101: found = 4'd5;
              4'b0001: found = 4'd6;
              4'b1001: found = 4'd7;
              default: found = PHASE_OFF;
            endcase
            if (mon_phase >= PHASE_OFF) begin
              mon_phase = found;
            end else if (found == PHASE_OFF) begin
              mon_error = ERR_TURN_OFF;
            end else begin
              phase_step = found[2:0] - mon_phase[2:0];
              if (phase_step == 3'd0 || phase_step == 3'd1 || phase_step == 3'd7) begin
                mon_phase = found;
              end else begin
                mon_error = ERR_JUMP;
              end
            end
          end
        end
      end
    end
    r.drive_pins = mon_driven;
    r.phase      = mon_phase;
    r.error_code = mon_error;
    return r;
  endfunction

  // one sample transaction, entered and left at a falling edge
  task automatic send_sample(input logic [3:0] pins, input logic [31:0] stamp);
    int      gap;
    sample_t s;
    s.pin_levels = pins;
    s.now_us     = stamp;
    gap = quiet_tx ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    do @(posedge clk); while (sample_stall !== 1'b0);
    status_queue.push_back(apply_pin_sample(s));
    @(negedge clk);
  endtask

  // stop offering samples and let every outstanding status word come back
  task automatic wait_for_status_drain();
    sample_valid <= 1'b0;
    wait (status_queue.size() == 0);
    // allow for the two-stage pipe
    repeat (4) @(negedge clk);
  endtask

  task automatic write_min_step(input logic [31:0] value);
    wait_for_status_drain();
    cfg_valid         <= 1'b1;
    cfg_min_step_time <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    mon_min_step = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly neighbouring phases, some noise, jumps and switch-offs
  task automatic send_random_step();
    int          base;
    int          pick;
    logic [3:0]  pins;
    logic [31:0] delta;
    base = (mon_phase < PHASE_OFF) ? int'(mon_phase) : $urandom_range(0, 7);
    pick = $urandom_range(0, 19);
    if (pick < 13) begin
      pins = STEP_PINS[3'((base + 7 + $urandom_range(0, 2)) % NUM_PHASES)];
    end else if (pick < 16) begin
      pins = 4'($urandom_range(0, 15));
    end else if (pick < 18) begin
      pins = STEP_PINS[3'((base + $urandom_range(2, 6)) % NUM_PHASES)];
    end else begin
      pins = 4'h0;
    end
    // spacing mostly just past the minimum, sometimes short or arbitrary
    case ($urandom_range(0, 9))
      0:       delta = $urandom;
      1:       delta = $urandom_range(0, mon_min_step);
      default: delta = mon_min_step + $urandom_range(0, 20);
    endcase
    send_sample(pins, mon_last_change + delta);
  endtask

  // full forward lap with wrap, backward across the wrap, then the error kinds
  task automatic test_phase_walk();
    logic [31:0] stamp;
    stamp = '0;
    write_min_step(32'd0);
    send_sample(4'h0, 32'h0000_0000);
    for (int p = 0; p <= NUM_PHASES; p++) begin
      stamp += 10;
      send_sample(STEP_PINS[3'(p % NUM_PHASES)], stamp);
    end
    send_sample(STEP_PINS[7], 32'hFFFF_FFFF);
    send_sample(STEP_PINS[6], 32'h0000_0005);
    // both lines of a coil high
    send_sample(4'hF, 32'h0000_0100);
    // motor switched off
    send_sample(4'h0, 32'h0000_0200);
    // jumps of more than one phase
    send_sample(4'h1, 32'h0000_0300);
    send_sample(4'h2, 32'h0000_0400);
  endtask

  // minimum step spacing: short, exact, two lines at once, timestamp wrap
  task automatic test_step_timing();
    write_min_step(32'd100);
    send_sample(mon_accepted ^ 4'h1, mon_last_change + 32'd50);
    send_sample(mon_accepted ^ 4'h1, mon_last_change + 32'd100);
    send_sample(mon_accepted ^ 4'h6, mon_last_change + 32'd200);
    send_sample(mon_accepted ^ 4'h8, 32'hFFFF_FFC0);
    send_sample(mon_accepted ^ 4'h8, 32'h0000_0010);
    send_sample(mon_accepted ^ 4'h8, 32'h0000_0024);
    // widest minimum: only an elapsed time of all ones gets through
    write_min_step(32'hFFFF_FFFF);
    send_sample(mon_accepted ^ 4'h2, mon_last_change + 32'hFFFF_FFFE);
    send_sample(mon_accepted ^ 4'h2, mon_last_change - 32'd1);
  endtask

  task automatic test_random_walks();
    logic [31:0] step_limits [6];
    int          count;
    step_limits[0] = 32'd0;
    step_limits[1] = 32'd1;
    step_limits[2] = 32'd25;
    step_limits[3] = $urandom_range(2, 1000);
    step_limits[4] = 32'hFFFF_FFFF;
    step_limits[5] = $urandom;
    for (int c = 0; c < 6; c++) begin
      write_min_step(step_limits[c]);
      count = (step_limits[c] == 32'hFFFF_FFFF) ? 60 : 150;
      for (int n = 0; n < count; n++) begin
        // every other setting opens with a stretch at full rate
        quiet_tx = (c % 2 == 1) && (n < 30);
        quiet_rx = quiet_tx;
        send_random_step();
      end
    end
    quiet_tx = 1'b0;
    quiet_rx = 1'b0;
  endtask

  // long receiver hold-off while samples keep coming, then a full drain pause
  task automatic test_backpressure();
    wait_for_status_drain();
    hold_left = HOLD_CYCLES;
    quiet_tx  = 1'b1;
    repeat (40) send_random_step();
    quiet_tx = 1'b0;
    wait_for_status_drain();
    repeat (20) send_random_step();
  endtask

  // receiver side: hold-off, per-transaction stall, or ready
  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // compare each result transaction with the oldest outstanding status word
  always @(posedge clk) begin
    result_t want;
    if (rst === 1'b0 && result_valid === 1'b1 && result_stall === 1'b0) begin
      stall_left = quiet_rx ? 0 : $urandom_range(0, 16);
      if (status_queue.size() == 0) begin
        status_errors++;
        if (status_errors <= 10) begin
          $display("unexpected result: drive=%h phase=%0d error=%0d",
                   result.drive_pins, result.phase, result.error_code);
        end
      end else begin
        want = status_queue.pop_front();
        if (result.drive_pins !== want.drive_pins || result.phase !== want.phase ||
            result.error_code !== want.error_code) begin
          status_errors++;
          if (status_errors <= 10) begin
            $display("status mismatch: expected %h/%0d/%0d, got %h/%0d/%0d (drive/phase/error)",
                     want.drive_pins, want.phase, want.error_code,
                     result.drive_pins, result.phase, result.error_code);
          end
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst === 1'b1 || (sample_valid === 1'b1 && sample_stall === 1'b0) ||
        (result_valid === 1'b1 && result_stall === 1'b0) ||
        (cfg_valid === 1'b1 && cfg_ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst               = 1'b1;
    sample_valid      = 1'b0;
    sample            = '0;
    cfg_valid         = 1'b0;
    cfg_min_step_time = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_phase_walk();
    test_step_timing();
    test_random_walks();
    test_backpressure();
    wait_for_status_drain();
    repeat (10) @(negedge clk);
    if (status_errors == 0 && status_queue.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
